// ===== rtl/tpd_pkg.sv =====
// Package: states, change bit indexes and shared types of the trace packet decoder.
package tpd_pkg;

  localparam int unsigned AddrStackDepth = 3;
  localparam int unsigned ChangeW        = 19;

  typedef enum logic [19:0] {
    ST_UNSYNCED   = 20'h00001,
    ST_IDLE       = 20'h00002,
    ST_WAIT_INFO  = 20'h00004,
    ST_PLCTL      = 20'h00008,
    ST_INFO       = 20'h00010,
    ST_KEY        = 20'h00020,
    ST_SPEC       = 20'h00040,
    ST_CYCT       = 20'h00080,
    ST_EXTENSION  = 20'h00100,
    ST_TIMESTAMP  = 20'h00200,
    ST_TS_CC      = 20'h00400,
    ST_COMMIT     = 20'h00800,
    ST_SHORT      = 20'h01000,
    ST_ADDR32     = 20'h02000,
    ST_ADDR64     = 20'h04000,
    ST_CONTEXT    = 20'h08000,
    ST_VCONTEXT   = 20'h10000,
    ST_CONTEXT_ID = 20'h20000,
    ST_EXC1       = 20'h40000,
    ST_EXC2       = 20'h80000
  } state_e;

  localparam int unsigned ChAddress  = 0;
  localparam int unsigned ChAtoms    = 1;
  localparam int unsigned ChStart    = 2;
  localparam int unsigned ChFnRet    = 3;
  localparam int unsigned ChExRet    = 4;
  localparam int unsigned ChDsync    = 5;
  localparam int unsigned ChUdsync   = 6;
  localparam int unsigned ChCtxId    = 7;
  localparam int unsigned ChVmId     = 8;
  localparam int unsigned ChExEntry  = 9;
  localparam int unsigned ChTstamp   = 10;
  localparam int unsigned ChCount    = 11;
  localparam int unsigned ChDiscard  = 12;
  localparam int unsigned ChStop     = 13;
  localparam int unsigned ChOverflow = 14;
  localparam int unsigned ChEvent0   = 15;

  localparam logic [7:0] SyncTail   = 8'h80;
  localparam logic [3:0] SyncZeros  = 4'd11;

  // Result word of one byte.
  typedef struct packed {
    logic [9:0]  mode_flags;
    logic [9:0]  exception_number;
    logic [31:0] vm_id;
    logic [31:0] context_id;
    logic [31:0] cycle_count;
    logic [63:0] timestamp;
    logic [23:0] atom_pattern;
    logic [2:0]  skip_atoms;
    logic [4:0]  exec_atoms;
    logic [63:0] address;
    logic [18:0] change_bits;
    logic        report;
  } result_t;

  typedef struct packed {
    logic [63:0] addr;
    logic        is1;
  } stack_entry_t;

  function automatic logic [1:0] pop3(input logic [2:0] v);
    return 2'(v[0]) + 2'(v[1]) + 2'(v[2]);
  endfunction

endpackage

// ===== rtl/tpd_core.sv =====
// Core: byte decoder state and the combinational next-state logic for one byte.
module tpd_core #(
  parameter int unsigned ADDR_STACK_DEPTH = tpd_pkg::AddrStackDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output tpd_pkg::result_t res_o
);
  import tpd_pkg::*;

  localparam int unsigned SelW = (ADDR_STACK_DEPTH > 1) ? $clog2(ADDR_STACK_DEPTH) : 1;

  state_e       st_q, st_d;
  logic [3:0]   zrun_q, zrun_d;
  logic         synced_q, synced_d;
  logic [3:0]   pctl_q, pctl_d;
  logic         cnt_en_q, cnt_en_d;
  logic         ctxf_q, ctxf_d;
  logic [31:0]  ctxw_q, ctxw_d, vmw_q, vmw_d;
  logic [7:0]   exc1_q, exc1_d;
  logic         cntf_q, cntf_d;
  logic [6:0]   boff_q, boff_d;
  logic [20:0]  cdelta_q, cdelta_d;
  stack_entry_t stk_q [ADDR_STACK_DEPTH];
  stack_entry_t stk_d [ADDR_STACK_DEPTH];

  logic [63:0] address_q, address_d, ts_q, ts_d;
  logic [31:0] cyc_q, cyc_d, ctxid_q, ctxid_d, vmid_q, vmid_d;
  logic [4:0]  exec_q, exec_d;
  logic [2:0]  skip_q, skip_d;
  logic [23:0] pat_q, pat_d;
  logic [9:0]  excn_q, excn_d;
  logic [1:0]  level_q, level_d;
  logic        is64_q, is64_d, sec_q, sec_d, ser_q, ser_d, ak_q, ak_d, ck_q, ck_d;
  logic [2:0]  smark_q, smark_d;

  logic [18:0] chg;
  logic        rep;

  // Replace w bits of v starting at pos with the low bits of b.
  function automatic logic [63:0] ins(input logic [63:0] v, input logic [6:0] pos,
                                      input logic [3:0] w, input logic [7:0] b);
    logic [63:0] m;
    m = ((64'd1 << w) - 64'd1) << pos[5:0];
    return (v & ~m) | ((64'(b) << pos[5:0]) & m);
  endfunction

  always_comb begin
    logic [6:0]  pos;
    logic [3:0]  w;
    logic [4:0]  k;
    logic [1:0]  p;
    logic [SelW-1:0] sel;
    logic [6:0]  tot;
    logic [1:0]  cp;
    logic [23:0] fpat;
    logic        do_push;
    stack_entry_t top;
    logic        set_at;
    logic [4:0]  ae;
    logic [2:0]  an;
    logic [23:0] ap;
    logic        is1;
    logic        lng, lctx, lwide;
    logic [7:0]  c;

    c = byte_i;
    st_d = st_q; zrun_d = zrun_q; synced_d = synced_q; pctl_d = pctl_q;
    cnt_en_d = cnt_en_q; ctxf_d = ctxf_q; ctxw_d = ctxw_q; vmw_d = vmw_q;
    exc1_d = exc1_q; cntf_d = cntf_q; boff_d = boff_q; cdelta_d = cdelta_q;
    stk_d = stk_q;
    address_d = address_q; ts_d = ts_q; cyc_d = cyc_q; ctxid_d = ctxid_q;
    vmid_d = vmid_q; exec_d = exec_q; skip_d = skip_q; pat_d = pat_q;
    excn_d = excn_q; level_d = level_q; is64_d = is64_q; sec_d = sec_q;
    ser_d = ser_q; ak_d = ak_q; ck_d = ck_q; smark_d = smark_q;
    chg = '0; rep = 1'b0;
    pos = '0; w = '0; k = '0; p = '0; sel = '0; tot = '0; cp = '0;
    fpat = '0; do_push = 1'b0; top = stk_q[0]; set_at = 1'b0; ae = '0; an = '0;
    ap = '0; is1 = 1'b0; lng = 1'b0; lctx = 1'b0; lwide = 1'b0;

    if (zrun_q == SyncZeros && c == SyncTail) begin
      synced_d = 1'b1;
      st_d = ST_WAIT_INFO;
    end else begin
      zrun_d = (c != 8'd0) ? 4'd0 : ((zrun_q < 4'd12) ? zrun_q + 4'd1 : 4'd12);
      case (st_q)
        ST_IDLE: begin
          if (c == 8'h01) st_d = ST_PLCTL;
          else if (c inside {8'hF6, 8'hF7}) begin
            set_at = 1'b1; ae = 5'(c[0]); an = 3'(!c[0]); ap = 24'(c[0]);
          end else if (c inside {[8'hD8:8'hDB]}) begin
            set_at = 1'b1; p = pop3({1'b0, c[1:0]});
            ae = 5'(p); an = 3'd2 - 3'(p); ap = 24'(c[1:0]);
          end else if (c >= 8'hF8) begin
            set_at = 1'b1; p = pop3(c[2:0]);
            ae = 5'(p); an = 3'd3 - 3'(p); ap = 24'(c[2:0]);
          end else if (c inside {[8'hDC:8'hDF]}) begin
            set_at = 1'b1;
            case (c[1:0])
              2'd0: begin ae = 5'd3; an = 3'd1; ap = 24'h0E; end
              2'd1: begin ae = 5'd0; an = 3'd4; ap = 24'h00; end
              2'd2: begin ae = 5'd2; an = 3'd2; ap = 24'h0A; end
              default: begin ae = 5'd2; an = 3'd2; ap = 24'h05; end
            endcase
          end else if (c == 8'hD5) begin set_at = 1'b1; ae = 5'd0; an = 3'd5; ap = 24'h00; end
          else if (c == 8'hD6) begin set_at = 1'b1; ae = 5'd2; an = 3'd3; ap = 24'h0A; end
          else if (c == 8'hD7) begin set_at = 1'b1; ae = 5'd3; an = 3'd2; ap = 24'h15; end
          else if (c == 8'hF5) begin set_at = 1'b1; ae = 5'd4; an = 3'd1; ap = 24'h1E; end
          else if (c inside {[8'hC0:8'hD4], [8'hE0:8'hF4]}) begin
            k = c[4:0];
            fpat = 24'((32'd1 << (k + 5'd4)) - 32'd1);
            set_at = 1'b1;
            if (c[5]) begin ae = k + 5'd3; an = 3'd1; ap = fpat & ~24'd1; end
            else begin ae = k + 5'd4; an = 3'd0; ap = fpat; end
          end else if (c inside {[8'h71:8'h7F]}) begin
            chg[ChEvent0 +: 4] = c[3:0];
          end else if (c == 8'h04) begin rep = 1'b1; chg[ChStart] = 1'b1; end
          else if (c inside {[8'h90:8'h93]}) begin
            sel = (32'(c[1:0]) > ADDR_STACK_DEPTH - 1) ? SelW'(ADDR_STACK_DEPTH - 1)
                                                      : SelW'(c[1:0]);
            top = stk_q[sel];
            do_push = 1'b1;
            address_d = top.addr; ak_d = 1'b1; chg[ChAddress] = 1'b1; rep = 1'b1;
          end else if (c inside {8'h95, 8'h96}) begin
            boff_d = (c == 8'h95) ? 7'd2 : 7'd1;
            do_push = 1'b1; top = stk_q[0];
            st_d = ST_SHORT;
          end else if (c inside {8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h82, 8'h83, 8'h85, 8'h86}) begin
            lng = 1'b1;
            is1 = (c inside {8'h9B, 8'h9E, 8'h83, 8'h86});
            lctx = (c inside {8'h82, 8'h83, 8'h85, 8'h86});
            lwide = (c inside {8'h9D, 8'h9E, 8'h85, 8'h86});
          end else if (c == 8'h81) st_d = ST_CONTEXT;
          else if (c == 8'h00) st_d = ST_EXTENSION;
          else if (c == 8'h08) begin synced_d = 1'b0; st_d = ST_UNSYNCED; end
          else if (c == 8'h06) st_d = ST_EXC1;
          else if (c inside {8'h02, 8'h03}) begin
            cntf_d = c[0];
            if (!c[0]) begin ck_d = 1'b0; cyc_d = '0; end
            boff_d = '0; st_d = ST_TIMESTAMP;
          end else if (c == 8'h05) begin rep = 1'b1; chg[ChFnRet] = 1'b1; end
          else if (c == 8'h07) begin rep = 1'b1; chg[ChExRet] = 1'b1; end
          else if (c inside {[8'h20:8'h27]}) begin
            smark_d = c[2:0]; rep = 1'b1; chg[ChDsync] = 1'b1;
          end else if (c inside {[8'h28:8'h2C]}) begin
            smark_d = c[2:0]; rep = 1'b1; chg[ChUdsync] = 1'b1;
          end else if (c == 8'h2D) begin boff_d = '0; st_d = ST_COMMIT; end
        end
        ST_WAIT_INFO: if (c == 8'h01) st_d = ST_PLCTL;
        ST_PLCTL: begin
          pctl_d = c[3:0];
          for (int i = 0; i < ADDR_STACK_DEPTH; i++) stk_d[i] = '0;
          if (c[0]) st_d = ST_INFO;
          else if (c[1]) st_d = ST_KEY;
          else if (c[2]) st_d = ST_SPEC;
          else if (c[3]) st_d = ST_CYCT;
          else begin rep = 1'b1; st_d = ST_IDLE; end
        end
        ST_INFO: begin
          cnt_en_d = c[0];
          if (pctl_q[1]) st_d = ST_KEY;
          else if (pctl_q[2]) st_d = ST_SPEC;
          else if (pctl_q[3]) st_d = ST_CYCT;
          else begin rep = 1'b1; st_d = ST_IDLE; end
        end
        ST_KEY: begin
          if (pctl_q[2]) st_d = ST_SPEC;
          else if (pctl_q[3]) st_d = ST_CYCT;
          else begin rep = 1'b1; st_d = ST_IDLE; end
        end
        ST_SPEC: begin
          if (pctl_q[3]) st_d = ST_CYCT;
          else begin rep = 1'b1; st_d = ST_IDLE; end
        end
        ST_CYCT: begin rep = 1'b1; st_d = ST_IDLE; end
        ST_EXTENSION: begin
          if (c == 8'h03) begin chg[ChDiscard] = 1'b1; chg[ChStop] = 1'b1; end
          else if (c == 8'h05) chg[ChOverflow] = 1'b1;
          rep = 1'b1; st_d = ST_IDLE;
        end
        ST_TIMESTAMP: begin
          pos = {1'b0, boff_q[5:0]};
          ts_d = ins(ts_q, pos, (pos < 7'd56) ? 4'd7 : 4'd8, c);
          boff_d = pos + 7'd7;
          if (!c[7] || boff_d >= 7'd63) begin
            if (ck_q) chg[ChTstamp] = 1'b1;
            if (cnt_en_q && cntf_q) begin
              boff_d = '0; cdelta_d = '0; st_d = ST_TS_CC;
            end else begin rep = 1'b1; st_d = ST_IDLE; end
          end
        end
        ST_TS_CC: begin
          cp = (boff_q > 7'd2) ? 2'd2 : boff_q[1:0];
          case (cp)
            2'd0:    cdelta_d = cdelta_q | 21'(c[6:0]);
            2'd1:    cdelta_d = cdelta_q | (21'(c[6:0]) << 7);
            default: cdelta_d = cdelta_q | (21'(c[6:0]) << 14);
          endcase
          boff_d = 7'(cp) + 7'd1;
          if (!c[7] || boff_d >= 7'd3) begin
            cyc_d = cyc_q + 32'(cdelta_d);
            ck_d = 1'b1; rep = 1'b1; chg[ChCount] = 1'b1; st_d = ST_IDLE;
          end
        end
        ST_COMMIT: begin
          boff_d = boff_q + 7'd1;
          if (!c[7] || boff_d >= 7'd5) st_d = ST_IDLE;
        end
        ST_SHORT: begin
          pos = {1'b0, boff_q[5:0]};
          w = (pos <= 7'd2) ? 4'd7 : 4'd8;
          stk_d[0].addr = ins(stk_q[0].addr, pos, w, c);
          boff_d = pos + 7'(w);
          if (!c[7] || boff_d > 7'd9) begin
            address_d = stk_d[0].addr; ak_d = 1'b1; chg[ChAddress] = 1'b1;
            rep = 1'b1; st_d = ST_IDLE;
          end
        end
        ST_ADDR32, ST_ADDR64: begin
          pos = {1'b0, boff_q[5:0]};
          tot = (st_q == ST_ADDR64) ? 7'd64 : 7'd32;
          if (pos < 7'd3) w = 4'd7;
          else if (pos < 7'd16) w = 4'(7'd16 - pos);
          else w = 4'd8;
          stk_d[0].addr = ins(stk_q[0].addr, pos, w, c);
          boff_d = pos + 7'(w);
          if (boff_d >= tot) begin
            address_d = stk_d[0].addr; ak_d = 1'b1; chg[ChAddress] = 1'b1;
            if (ctxf_q) st_d = ST_CONTEXT;
            else begin rep = 1'b1; st_d = ST_IDLE; end
          end
        end
        ST_CONTEXT: begin
          level_d = c[1:0]; is64_d = c[4]; sec_d = !c[5]; ctxf_d = c[7];
          boff_d = '0;
          if (c[6]) begin vmw_d = '0; st_d = ST_VCONTEXT; end
          else if (c[7]) begin ctxw_d = '0; st_d = ST_CONTEXT_ID; end
          else begin rep = 1'b1; chg[ChCtxId] = 1'b1; st_d = ST_IDLE; end
        end
        ST_VCONTEXT: begin
          vmw_d = vmw_q | (32'(c) << boff_q[4:3] * 8);
          boff_d = {2'b0, boff_q[4:3], 3'b0} + 7'd8;
          if (boff_d >= 7'd32) begin
            vmid_d = vmw_d; chg[ChVmId] = 1'b1; boff_d = '0;
            if (ctxf_q) begin ctxw_d = '0; st_d = ST_CONTEXT_ID; end
            else begin rep = 1'b1; st_d = ST_IDLE; end
          end
        end
        ST_CONTEXT_ID: begin
          ctxw_d = ctxw_q | (32'(c) << boff_q[4:3] * 8);
          boff_d = {2'b0, boff_q[4:3], 3'b0} + 7'd8;
          if (boff_d >= 7'd32) begin
            ctxid_d = ctxw_d; rep = 1'b1; chg[ChCtxId] = 1'b1; st_d = ST_IDLE;
          end
        end
        ST_EXC1: begin exc1_d = c; st_d = ST_EXC2; end
        ST_EXC2: begin
          excn_d = {c[4:0], exc1_q[5:1]};
          ser_d = c[5]; chg[ChExEntry] = 1'b1; st_d = ST_IDLE;
        end
        default: ;
      endcase

      if (set_at) begin
        exec_d = ae; skip_d = an; pat_d = ap;
        if (ak_q) begin rep = 1'b1; chg[ChAtoms] = 1'b1; end
      end
      if (lng) begin
        boff_d = is1 ? 7'd1 : 7'd2;
        ctxf_d = lctx;
        do_push = 1'b1;
        top.is1 = is1;
        top.addr = stk_q[0].addr & (is1 ? 64'hFFFF_FFFE : 64'hFFFF_FFFC);
        st_d = lwide ? ST_ADDR64 : ST_ADDR32;
      end
      // Shift the stack down by one and write the new top.
      if (do_push) begin
        for (int i = ADDR_STACK_DEPTH - 1; i > 0; i--) stk_d[i] = stk_q[i-1];
        stk_d[0] = top;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_UNSYNCED; zrun_q <= '0; synced_q <= 1'b0; pctl_q <= '0;
      cnt_en_q <= 1'b0; ctxf_q <= 1'b0; ctxw_q <= '0; vmw_q <= '0; exc1_q <= '0;
      cntf_q <= 1'b0; boff_q <= '0; cdelta_q <= '0;
      for (int i = 0; i < ADDR_STACK_DEPTH; i++) stk_q[i] <= '0;
      address_q <= '0; ts_q <= '0; cyc_q <= '0; ctxid_q <= '0; vmid_q <= '0;
      exec_q <= '0; skip_q <= '0; pat_q <= '0; excn_q <= '0; level_q <= '0;
      is64_q <= 1'b0; sec_q <= 1'b0; ser_q <= 1'b0; ak_q <= 1'b0; ck_q <= 1'b0;
      smark_q <= '0;
    end else if (step_i) begin
      st_q <= st_d; zrun_q <= zrun_d; synced_q <= synced_d; pctl_q <= pctl_d;
      cnt_en_q <= cnt_en_d; ctxf_q <= ctxf_d; ctxw_q <= ctxw_d; vmw_q <= vmw_d;
      exc1_q <= exc1_d; cntf_q <= cntf_d; boff_q <= boff_d; cdelta_q <= cdelta_d;
      stk_q <= stk_d;
      address_q <= address_d; ts_q <= ts_d; cyc_q <= cyc_d; ctxid_q <= ctxid_d;
      vmid_q <= vmid_d; exec_q <= exec_d; skip_q <= skip_d; pat_q <= pat_d;
      excn_q <= excn_d; level_q <= level_d; is64_q <= is64_d; sec_q <= sec_d;
      ser_q <= ser_d; ak_q <= ak_d; ck_q <= ck_d; smark_q <= smark_d;
    end
  end

  always_comb begin
    res_o.report           = rep && synced_d;
    res_o.change_bits      = chg;
    res_o.address          = address_d;
    res_o.exec_atoms       = exec_d;
    res_o.skip_atoms       = skip_d;
    res_o.atom_pattern     = pat_d;
    res_o.timestamp        = ts_d;
    res_o.cycle_count      = cyc_d;
    res_o.context_id       = ctxid_d;
    res_o.vm_id            = vmid_d;
    res_o.exception_number = excn_d;
    res_o.mode_flags       = {ck_d, ak_d, smark_d, ser_d, sec_d, is64_d, level_d};
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(st_q))
    else $error("decoder state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni) zrun_q <= 4'd12)
    else $error("zero run over saturation");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && zrun_q == SyncZeros && byte_i == SyncTail) |=> synced_q && st_q == ST_WAIT_INFO)
    else $error("sync sequence not taken");

endmodule

// ===== rtl/trace_packet_decoder.sv =====
// Top level: stream wrapper around the trace byte decoder with a result register.
// The decoder takes one trace byte per word on the slave side and returns one
// result word per byte on the master side. Each byte is decoded by the core's
// next-state logic and the result is registered, so it appears in the cycle
// after the byte is taken; a new byte is accepted every cycle while the result
// register is empty or is being taken, so throughput is one byte per cycle. The
// decoder waits for exactly eleven zero bytes then 0x80 before it reports anything.
module trace_packet_decoder #(
  parameter int unsigned ADDR_STACK_DEPTH = tpd_pkg::AddrStackDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] trace_byte
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [0] report, [19:1] change_bits, [83:20] address, [88:84] exec_atoms,
  // [91:89] skip_atoms, [115:92] atom_pattern, [179:116] timestamp,
  // [211:180] cycle_count, [243:212] context_id, [275:244] vm_id,
  // [285:276] exception_number, [295:286] mode_flags, [303:296] zero fill
  output logic [303:0] m_axis_tdata_o
);
  import tpd_pkg::*;

  result_t res;
  result_t res_q;
  logic    vld_q;
  logic    take;

  // Accept when the result slot is free or drains this cycle.
  assign s_axis_tready_o = !vld_q || m_axis_tready_i;
  assign take = s_axis_tvalid_i && s_axis_tready_o;

  tpd_core #(.ADDR_STACK_DEPTH(ADDR_STACK_DEPTH)) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (take),
    .byte_i (s_axis_tdata_i),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o  = {8'd0, res_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni) take |=> m_axis_tvalid_o)
    else $error("accepted word produced no result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken over a stalled result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule
